// ----- rtl/movm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package movm_pkg;

  localparam int NUM_CHANNELS_DEF = 16;

  // Driver operation codes
  localparam logic [2:0] OP_NOTE_OFF  = 3'd0;
  localparam logic [2:0] OP_NOTE_ON   = 3'd1;
  localparam logic [2:0] OP_CONTROL   = 3'd2;
  localparam logic [2:0] OP_PROGRAM   = 3'd3;
  localparam logic [2:0] OP_BEND      = 3'd4;
  localparam logic [2:0] OP_MASTER    = 3'd5;
  localparam logic [2:0] OP_SOUND     = 3'd6;

  // MIDI command nibbles
  localparam logic [7:0] CMD_NOTE_OFF = 8'h80;
  localparam logic [7:0] CMD_NOTE_ON  = 8'h90;
  localparam logic [7:0] CMD_CONTROL  = 8'hB0;
  localparam logic [7:0] CMD_PROGRAM  = 8'hC0;
  localparam logic [7:0] CMD_BEND     = 8'hE0;

  localparam logic [7:0] CTL_VOLUME   = 8'h07;
  localparam logic [7:0] CTL_ALL_OFF  = 8'h7B;
  localparam logic [7:0] BAR_QUERY    = 8'hFF;
  localparam logic [3:0] BAR_MAX      = 4'hF;
  localparam logic [6:0] VOL_FULL     = 7'h7F;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic step;     // emit the next broadcast message
  } movm_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic slot_free;  // output register empty or being drained
    logic bcast_req;  // current input item starts a volume broadcast
    logic idx_zero;   // broadcast has reached channel 0
  } movm_stat_t;

  // Master scale for each volume bar
  function automatic logic [6:0] bar_scale(input logic [3:0] bar);
    logic [6:0] s;
    case (bar)
      4'd0:    s = 7'h01;
      4'd1:    s = 7'h08;
      4'd2:    s = 7'h11;
      4'd3:    s = 7'h19;
      4'd4:    s = 7'h22;
      4'd5:    s = 7'h2A;
      4'd6:    s = 7'h32;
      4'd7:    s = 7'h3B;
      4'd8:    s = 7'h43;
      4'd9:    s = 7'h4C;
      4'd10:   s = 7'h54;
      4'd11:   s = 7'h5C;
      4'd12:   s = 7'h65;
      4'd13:   s = 7'h6D;
      4'd14:   s = 7'h76;
      default: s = 7'h7F;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/midi_output_volume_mixer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// MIDI output volume mixer.
// Input channel (in_*): one driver command per transaction; in_tuser carries the
// operation code, in_tdata the channel, data1 and data2.
// Output channel (out_*): one MIDI message per transaction; out_tuser flags a
// message to send (low for a master volume answer without broadcast, which only
// reports the previous bar), out_tlast marks the final message of a command.
// The result of a single-message command appears in the output register the
// cycle after the input transaction. A master volume or sound on/off broadcast
// is accepted and then emits NUM_CHANNELS messages, channel NUM_CHANNELS-1 down
// to 0, one per cycle while the output is not stalled, through the one
// shared 7x7 multiplier that scales each stored channel volume.
// in_tready stays low until a broadcast has emitted its last message; commands
// with no result (unused code, sound query, controller 7 while sound is off)
// put no message in the output register.
// Reset: all channel volumes return to 127, bar to 15, master scale to 127,
// sound on; the output register empties. No clearing pass is needed.
// Stall: while out_tready is low and a message waits, hold it and the
// broadcast; in_tready is low until the waiting message is taken.
module midi_output_volume_mixer #(
  parameter int NUM_CHANNELS = movm_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // channel[3:0], data1[11:4], data2[18:12], zero
  input  wire logic [2:0]  in_tuser,   // operation[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // status_byte[7:0], first_data[14:8],
                                       // second_data[21:15], previous_bar[25:22], zero
  output logic             out_tuser,  // send_valid
  output logic             out_tlast   // last_of_run
);

  movm_pkg::movm_cmd_t  cmd;
  movm_pkg::movm_stat_t stat;

  logic [7:0] status_byte;
  logic [6:0] first_data, second_data;
  logic [3:0] previous_bar;

  // Sequencer: accepts commands and steps the broadcast
  movm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Volume state, scaling and output register
  movm_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (in_tuser),
    .channel      (in_tdata[3:0]),
    .data1        (in_tdata[11:4]),
    .data2        (in_tdata[18:12]),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .send_valid   (out_tuser),
    .status_byte  (status_byte),
    .first_data   (first_data),
    .second_data  (second_data),
    .previous_bar (previous_bar),
    .last_of_run  (out_tlast)
  );

  assign out_tdata = {6'd0, previous_bar, second_data, first_data, status_byte};

endmodule

`default_nettype wire

// ----- rtl/movm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module movm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire movm_pkg::movm_stat_t stat,
  output movm_pkg::movm_cmd_t    cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_BCAST = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    in_tready  = (state_r == ST_IDLE) && stat.slot_free;
    cmd.accept = in_tvalid && in_tready;
    cmd.step   = (state_r == ST_BCAST) && stat.slot_free;
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && stat.bcast_req) state_nxt = ST_BCAST;
      end
      ST_BCAST: begin
        if (cmd.step && stat.idx_zero) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/movm_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module movm_dpath #(
  parameter int NUM_CHANNELS = movm_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire movm_pkg::movm_cmd_t cmd,
  output movm_pkg::movm_stat_t   stat,
  input  wire logic [2:0]        operation,
  input  wire logic [3:0]        channel,
  input  wire logic [7:0]        data1,
  input  wire logic [6:0]        data2,
  input  wire logic              out_tready,
  output logic                   out_valid,
  output logic                   send_valid,
  output logic [7:0]             status_byte,
  output logic [6:0]             first_data,
  output logic [6:0]             second_data,
  output logic [3:0]             previous_bar,
  output logic                   last_of_run
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [6:0]      vol_r [NUM_CHANNELS];
  logic [3:0]      bar_r, bar_nxt;
  logic [6:0]      master_r, master_nxt;
  logic            snd_r, snd_nxt;
  logic [6:0]      bc_scale_r, bc_scale_nxt;
  logic [3:0]      bc_prev_r, bc_prev_nxt;
  logic [CH_W-1:0] idx_r;

  logic            out_valid_r;
  logic            send_r;
  logic [7:0]      status_r;
  logic [6:0]      first_r, second_r;
  logic [3:0]      prev_r;
  logic            last_r;

  // Single-result decode
  logic            single;
  logic            s_send;
  logic [7:0]      s_status;
  logic [6:0]      s_first, s_second;
  logic [3:0]      s_prev;
  logic            s_scaled;   // second byte comes from the multiplier
  logic            bcast;
  logic            vol_we;
  logic [3:0]      bar_sat;

  logic [6:0]      mul_a, mul_b;
  logic [13:0]     prod;

  always_comb begin
    bar_sat      = (data1 > {4'd0, movm_pkg::BAR_MAX}) ? movm_pkg::BAR_MAX : data1[3:0];
    single       = 1'b0;
    s_send       = 1'b1;
    s_status     = '0;
    s_first      = data1[6:0];
    s_second     = data2;
    s_prev       = '0;
    s_scaled     = 1'b0;
    bcast        = 1'b0;
    vol_we       = 1'b0;
    bar_nxt      = bar_r;
    master_nxt   = master_r;
    snd_nxt      = snd_r;
    bc_scale_nxt = bc_scale_r;
    bc_prev_nxt  = bc_prev_r;
    unique case (operation)
      movm_pkg::OP_NOTE_OFF: begin
        single   = 1'b1;
        s_status = movm_pkg::CMD_NOTE_OFF | {4'd0, channel};
      end
      movm_pkg::OP_NOTE_ON: begin
        single   = 1'b1;
        s_status = movm_pkg::CMD_NOTE_ON | {4'd0, channel};
      end
      movm_pkg::OP_CONTROL: begin
        s_status = movm_pkg::CMD_CONTROL | {4'd0, channel};
        if (data1 == movm_pkg::CTL_VOLUME) begin
          vol_we   = 1'b1;
          single   = snd_r;
          s_scaled = 1'b1;
        end else if (data1 == movm_pkg::CTL_ALL_OFF) begin
          single   = 1'b1;
          s_second = '0;
        end else begin
          single   = 1'b1;
        end
      end
      movm_pkg::OP_PROGRAM: begin
        single   = 1'b1;
        s_status = movm_pkg::CMD_PROGRAM | {4'd0, channel};
        s_second = '0;
      end
      movm_pkg::OP_BEND: begin
        single   = 1'b1;
        s_status = movm_pkg::CMD_BEND | {4'd0, channel};
      end
      movm_pkg::OP_MASTER: begin
        s_send   = 1'b0;
        s_first  = '0;
        s_second = '0;
        s_prev   = bar_r;
        if (data1 != movm_pkg::BAR_QUERY) begin
          bar_nxt = bar_sat;
          if (snd_r) begin
            master_nxt   = movm_pkg::bar_scale(bar_sat);
            bc_scale_nxt = movm_pkg::bar_scale(bar_sat);
            bc_prev_nxt  = bar_r;
            bcast        = 1'b1;
          end
        end
        single = !bcast;
      end
      movm_pkg::OP_SOUND: begin
        if (data1 != movm_pkg::BAR_QUERY) begin
          bcast       = 1'b1;
          bc_prev_nxt = '0;
          if (data1 != 8'd0) begin
            snd_nxt      = 1'b1;
            bc_scale_nxt = movm_pkg::bar_scale(bar_r);
          end else begin
            snd_nxt      = 1'b0;
            bc_scale_nxt = '0;
          end
        end
      end
      default: begin
        single = 1'b0;
      end
    endcase
  end

  // One shared 7x7 multiplier: broadcast volume or a fresh controller 7 value
  assign mul_a = cmd.step ? bc_scale_r    : master_r;
  assign mul_b = cmd.step ? vol_r[idx_r]  : data2;
  assign prod  = {7'd0, mul_a} * {7'd0, mul_b};

  assign stat.slot_free = !out_valid_r || out_tready;
  assign stat.bcast_req = bcast;
  assign stat.idx_zero  = (idx_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) vol_r[i] <= movm_pkg::VOL_FULL;
      bar_r       <= movm_pkg::BAR_MAX;
      master_r    <= movm_pkg::VOL_FULL;
      snd_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        bar_r    <= bar_nxt;
        master_r <= master_nxt;
        snd_r    <= snd_nxt;
        if (vol_we && ({1'b0, channel} < 5'(NUM_CHANNELS)))
          vol_r[channel[CH_W-1:0]] <= data2;
      end
      if ((cmd.accept && single) || cmd.step) out_valid_r <= 1'b1;
      else if (out_tready)                    out_valid_r <= 1'b0;
    end
  end

  // Payload and broadcast working registers
  always_ff @(posedge clk) begin
    if (cmd.accept && bcast) begin
      bc_scale_r <= bc_scale_nxt;
      bc_prev_r  <= bc_prev_nxt;
      idx_r      <= CH_W'(NUM_CHANNELS - 1);
    end else if (cmd.step) begin
      idx_r <= idx_r - 1'b1;
    end
    if (cmd.step) begin
      send_r   <= 1'b1;
      status_r <= movm_pkg::CMD_CONTROL | 8'(idx_r);
      first_r  <= movm_pkg::CTL_VOLUME[6:0];
      second_r <= prod[13:7];
      prev_r   <= bc_prev_r;
      last_r   <= (idx_r == '0);
    end else if (cmd.accept && single) begin
      send_r   <= s_send;
      status_r <= s_status;
      first_r  <= s_first;
      second_r <= s_scaled ? prod[13:7] : s_second;
      prev_r   <= s_prev;
      last_r   <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign send_valid   = send_r;
  assign status_byte  = status_r;
  assign first_data   = first_r;
  assign second_data  = second_r;
  assign previous_bar = prev_r;
  assign last_of_run  = last_r;

endmodule

`default_nettype wire

// ----- rtl/movm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module movm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // A stalled message holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output message changed while stalled");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid straight after reset");

  // A query answer stands alone and carries no MIDI bytes
  a_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[21:0] == 22'd0))
    else $error("malformed query answer");

  // A sent message has a status byte
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7])
    else $error("status byte without top bit");

  // A command is taken only when a waiting message drains
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid || out_tready)
    else $error("command taken over a waiting message");

endmodule

bind midi_output_volume_mixer movm_checker u_movm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
